/* hw/rtl/pkr_pkg.sv */
// types and constants shared by the packet record packer modules
package pkr_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_packet;
    logic [14:0] packet_length;
    logic [63:0] stamp;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       record_end;
    logic       batch_end;
    logic       run_last;
  } out_req_t;

  typedef enum logic {
    CMD_DATA,
    CMD_PACKET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [14:0] len;
    logic [63:0] stamp;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] record_bytes;
    logic [15:0] records_in_batch;
  } cfg_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_BYTES     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORDS_IN_BATCH = 2'd1;

  localparam logic [15:0] RECORD_BYTES_RESET     = 16'd1024;
  localparam logic [15:0] RECORDS_IN_BATCH_RESET = 16'd16;
  localparam logic [15:0] RECORD_BYTES_MIN       = 16'd16;

  localparam int LEN_WORD_BYTES = 4;
  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int CMD_QUEUE_AW = $clog2(CMD_QUEUE_DEPTH);

endpackage

/* hw/rtl/packet_record_packer_top.sv */
// top level of the packet record packer: config registers, front, queue, back
//
// channel  | direction | handshake           | payload
// in       | input     | in_valid/in_ready   | in_data (pkr_pkg::in_req_t)
// out      | output    | out_valid/out_ready | out_data (pkr_pkg::out_req_t)
// cfg      | input     | cfg_valid/cfg_ready | cfg_index, cfg_value
//
// one output byte per cycle from the back end output register while out_ready allows
// a packet's first byte yields 5 + STAMP_BYTES output bytes (one pad byte dropping the
// packet if one record byte is left); the 4-entry command queue absorbs header time
// in_ready drops only while the command queue is full; out_ready low stalls the back end
// synchronous reset clears queue, counters and record position; no clearing pass
module packet_record_packer_top #(
  parameter int STAMP_BYTES      = 8,
  parameter int MAX_PACKET_BYTES = 16384
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pkr_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pkr_pkg::out_req_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pkr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_value
);

  pkr_pkg::cfg_t  cfg;
  pkr_pkg::push_t q_push;
  pkr_pkg::cmd_t  head;
  logic           q_full;
  logic           head_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.record_bytes     <= pkr_pkg::RECORD_BYTES_RESET;
      cfg.records_in_batch <= pkr_pkg::RECORDS_IN_BATCH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pkr_pkg::CFG_RECORD_BYTES:     cfg.record_bytes     <= cfg_value;
        pkr_pkg::CFG_RECORDS_IN_BATCH: cfg.records_in_batch <= cfg_value;
        default: begin
        end
      endcase
    end
  end

  pkr_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  pkr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_push    (q_push),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head)
  );

  pkr_back #(
    .STAMP_BYTES(STAMP_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_batch_on_record_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.batch_end || out_data.record_end))
    else $error("batch end without record end");

  a_packet_queued: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.first_of_packet) |=> head_valid)
    else $error("accepted packet start not queued");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

/* hw/rtl/pkr_front.sv */
// front end: accepts packet bytes, clamps lengths, tracks open packet, queues commands
module pkr_front #(
  parameter int MAX_PACKET_BYTES = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pkr_pkg::in_req_t in_data,
  input  logic             q_full,
  output pkr_pkg::push_t   q_push
);

  logic [14:0] payload_left;
  logic [14:0] payload_left_next;
  logic [14:0] len_c;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (in_data.packet_length == 15'd0) begin
      len_c = 15'd1;
    end else if ({1'b0, in_data.packet_length} > 16'(MAX_PACKET_BYTES)) begin
      len_c = 15'(MAX_PACKET_BYTES);
    end else begin
      len_c = in_data.packet_length;
    end
  end

  always_comb begin
    payload_left_next = payload_left;
    q_push.push       = 1'b0;
    q_push.cmd.kind   = in_data.first_of_packet ? pkr_pkg::CMD_PACKET : pkr_pkg::CMD_DATA;
    q_push.cmd.len    = len_c;
    q_push.cmd.stamp  = in_data.stamp;
    q_push.cmd.data   = in_data.data_byte;
    if (accept) begin
      if (in_data.first_of_packet) begin
        payload_left_next = len_c - 15'd1;
        q_push.push       = 1'b1;
      end else if (payload_left != 15'd0) begin
        payload_left_next = payload_left - 15'd1;
        q_push.push       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_left <= 15'd0;
    end else begin
      payload_left <= payload_left_next;
    end
  end

endmodule

/* hw/rtl/pkr_queue.sv */
// short command queue between front and back
module pkr_queue (
  input  logic           clk,
  input  logic           rst,
  input  pkr_pkg::push_t q_push,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output pkr_pkg::cmd_t  head
);

  localparam int AW = pkr_pkg::CMD_QUEUE_AW;

  pkr_pkg::cmd_t entries [pkr_pkg::CMD_QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full       = count == (AW+1)'(pkr_pkg::CMD_QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = q_push.push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

/* hw/rtl/pkr_back.sv */
// back end: emits header and data bytes, tracks record and batch boundaries
module pkr_back #(
  parameter int STAMP_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  pkr_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  pkr_pkg::cmd_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pkr_pkg::out_req_t out_data
);

  localparam int HDR_LAST = pkr_pkg::LEN_WORD_BYTES + STAMP_BYTES;
  localparam int IDX_W    = $clog2(HDR_LAST + 1);

  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic [IDX_W-1:0] st_idx;
  logic [15:0]      space_left;
  logic [15:0]      space_left_next;
  logic [15:0]      record_count;
  logic [15:0]      record_count_next;
  logic             dropping;
  logic             dropping_next;
  logic [15:0]      eff_record;
  logic [15:0]      eff_batch;
  logic [15:0]      sl_dec;
  logic [15:0]      rc_inc;
  logic             rend;
  logic             bend;
  logic [31:0]      len_word;
  logic [7:0]       hdr_byte;
  logic             can_emit;
  logic             emit;
  logic             run_last;
  logic [7:0]       byte_sel;

  assign eff_record = (cfg.record_bytes < pkr_pkg::RECORD_BYTES_MIN) ?
                      pkr_pkg::RECORD_BYTES_MIN : cfg.record_bytes;
  assign eff_batch  = (cfg.records_in_batch == 16'd0) ? 16'd1 : cfg.records_in_batch;

  // record and batch accounting for one emitted byte
  assign sl_dec = space_left - 16'd1;
  assign rc_inc = record_count + 16'd1;
  assign rend   = sl_dec == 16'd0;
  assign bend   = rend && (rc_inc >= eff_batch);

  assign len_word = 32'(head.len) + 32'(STAMP_BYTES);
  assign st_idx   = idx - IDX_W'(pkr_pkg::LEN_WORD_BYTES);

  always_comb begin
    if (idx < IDX_W'(pkr_pkg::LEN_WORD_BYTES)) begin
      hdr_byte = len_word[{idx[1:0], 3'b000} +: 8];
    end else if (idx < IDX_W'(HDR_LAST)) begin
      hdr_byte = head.stamp[{st_idx[2:0], 3'b000} +: 8];
    end else begin
      hdr_byte = head.data;
    end
  end

  assign can_emit = !out_valid || out_ready;

  always_comb begin
    emit          = 1'b0;
    pop           = 1'b0;
    run_last      = 1'b0;
    byte_sel      = head.data;
    idx_next      = idx;
    dropping_next = dropping;
    if (head_valid) begin
      case (head.kind)
        pkr_pkg::CMD_DATA: begin
          if (dropping) begin
            pop = 1'b1;
          end else if (can_emit) begin
            emit     = 1'b1;
            run_last = 1'b1;
            pop      = 1'b1;
          end
        end
        pkr_pkg::CMD_PACKET: begin
          if (can_emit) begin
            emit = 1'b1;
            if (idx == '0 && space_left == 16'd1) begin
              // pad the last byte and drop the packet
              byte_sel      = 8'd0;
              run_last      = 1'b1;
              pop           = 1'b1;
              dropping_next = 1'b1;
            end else begin
              byte_sel      = hdr_byte;
              dropping_next = 1'b0;
              if (idx == IDX_W'(HDR_LAST)) begin
                run_last = 1'b1;
                pop      = 1'b1;
                idx_next = '0;
              end else begin
                idx_next = idx + IDX_W'(1);
              end
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    space_left_next   = space_left;
    record_count_next = record_count;
    if (emit) begin
      space_left_next = rend ? eff_record : sl_dec;
      if (rend) begin
        record_count_next = bend ? 16'd0 : rc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx          <= '0;
      space_left   <= pkr_pkg::RECORD_BYTES_RESET;
      record_count <= 16'd0;
      dropping     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      idx          <= idx_next;
      space_left   <= space_left_next;
      record_count <= record_count_next;
      dropping     <= dropping_next;
      if (can_emit) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_emit && emit) begin
      out_data.out_byte   <= byte_sel;
      out_data.record_end <= rend;
      out_data.batch_end  <= bend;
      out_data.run_last   <= run_last;
    end
  end

endmodule

/* tb/packet_record_packer_top_test.sv */
`timescale 1ns / 1ps
// self-checking testbench for the packet record packer: random packets against a byte predictor
module packet_record_packer_top_test;

  localparam int STAMP_BYTES      = 8;
  localparam int MAX_PACKET_BYTES = 16384;
  localparam int DRAIN_CYCLES     = 64;
  localparam logic [pkr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  class record_scoreboard;
    logic [15:0]       record_bytes_reg;
    logic [15:0]       batch_reg;
    int unsigned       space_left;
    int unsigned       payload_left;
    int unsigned       record_count;
    bit                dropping;
    int                records_closed;
    int                mismatches;
    pkr_pkg::out_req_t pending_bytes[$];
    pkr_pkg::out_req_t held;
    bit                holding;

    function new();
      record_bytes_reg = pkr_pkg::RECORD_BYTES_RESET;
      batch_reg        = pkr_pkg::RECORDS_IN_BATCH_RESET;
      space_left       = record_size();
      payload_left     = 0;
      record_count     = 0;
      dropping         = 0;
      records_closed   = 0;
      mismatches       = 0;
      holding          = 0;
    endfunction

    function int unsigned record_size();
      return 32'((record_bytes_reg < pkr_pkg::RECORD_BYTES_MIN) ?
                 pkr_pkg::RECORD_BYTES_MIN : record_bytes_reg);
    endfunction

    function int unsigned batch_limit();
      return (batch_reg == 16'd0) ? 1 : 32'(batch_reg);
    endfunction

    function void set_register(logic [pkr_pkg::CFG_INDEX_W-1:0] index, logic [15:0] value);
      if (index == pkr_pkg::CFG_RECORD_BYTES) begin
        record_bytes_reg = value;
      end else if (index == pkr_pkg::CFG_RECORDS_IN_BATCH) begin
        batch_reg = value;
      end
    endfunction

    // one record byte, with record and batch closing
    function void place_byte(logic [7:0] b);
      pkr_pkg::out_req_t r;
      r.out_byte   = b;
      r.record_end = 1'b0;
      r.batch_end  = 1'b0;
      r.run_last   = 1'b0;
      if (space_left > 0) space_left--;
      if (space_left == 0) begin
        r.record_end = 1'b1;
        records_closed++;
        record_count = (record_count + 1) & 16'hFFFF;
        if (record_count >= batch_limit()) begin
          r.batch_end  = 1'b1;
          record_count = 0;
        end
        space_left = record_size();
      end
      if (holding) pending_bytes.push_back(held);
      held    = r;
      holding = 1;
    endfunction

    function void note_request(pkr_pkg::in_req_t req);
      int unsigned len;
      logic [31:0] word;
      if (req.first_of_packet) begin
        len = 32'(req.packet_length);
        if (len == 0) len = 1;
        if (len > MAX_PACKET_BYTES) len = MAX_PACKET_BYTES;
        payload_left = len;
        dropping     = 0;
        if (space_left < 2) begin
          place_byte(8'h00);
          dropping = 1;
          payload_left--;
        end else begin
          word = len + STAMP_BYTES;
          for (int i = 0; i < pkr_pkg::LEN_WORD_BYTES; i++) place_byte(word[8*i +: 8]);
          for (int i = 0; i < STAMP_BYTES; i++) place_byte(req.stamp[8*i +: 8]);
          place_byte(req.data_byte);
          payload_left--;
        end
      end else if (payload_left > 0) begin
        payload_left--;
        if (!dropping) place_byte(req.data_byte);
      end
      if (payload_left == 0) dropping = 0;
      if (holding) begin
        held.run_last = 1'b1;
        pending_bytes.push_back(held);
        holding = 0;
      end
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatches++;
    endfunction

    function void check_byte(pkr_pkg::out_req_t got);
      pkr_pkg::out_req_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: out_byte expected none got %0h", $time, got.out_byte);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte) report("out_byte", want.out_byte, got.out_byte);
      if (got.record_end !== want.record_end)
        report("record_end", 8'(want.record_end), 8'(got.record_end));
      if (got.batch_end !== want.batch_end)
        report("batch_end", 8'(want.batch_end), 8'(got.batch_end));
      if (got.run_last !== want.run_last)
        report("run_last", 8'(want.run_last), 8'(got.run_last));
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  pkr_pkg::in_req_t                in_data;
  logic                            out_valid;
  logic                            out_ready;
  pkr_pkg::out_req_t               out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [pkr_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]                     cfg_value;

  record_scoreboard sb;
  bit               steady;
  int               items_sent;

  packet_record_packer_top #(
    .STAMP_BYTES      (STAMP_BYTES),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  function automatic pkr_pkg::in_req_t make_req(bit first, logic [7:0] data,
                                                logic [14:0] len, logic [63:0] stamp);
    pkr_pkg::in_req_t r;
    r.data_byte       = data;
    r.first_of_packet = first;
    r.packet_length   = len;
    r.stamp           = stamp;
    return r;
  endfunction

  task automatic send_request(input pkr_pkg::in_req_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
  endtask

  task automatic send_packet(input int len_field, input int nbytes);
    int eff;
    eff = (len_field == 0) ? 1 : ((len_field > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES : len_field);
    for (int i = 0; i < nbytes; i++) begin
      send_request(make_req(i == 0, 8'($urandom_range(0, 255)),
                            15'((i == 0) ? len_field : $urandom_range(0, 32767)),
                            rand_stamp()));
    end
    items_sent += (nbytes < eff) ? nbytes : eff;
  endtask

  task automatic random_packet(input int max_len);
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 15 && sb.space_left >= 14 && sb.space_left <= 64) begin
      // end the record exactly or with one byte left
      len = sb.space_left - 12 - $urandom_range(0, 1);
      send_packet(len, len);
    end else if (pick < 70) begin
      len = $urandom_range(1, max_len);
      send_packet((len == 1 && pick % 2 == 0) ? 0 : len, len);
    end else if (pick < 82) begin
      send_packet($urandom_range(0, 32767), $urandom_range(1, 6));
    end else if (pick < 90) begin
      len = $urandom_range(1, max_len);
      send_packet(len, len + $urandom_range(1, 3));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        send_request(make_req(1'b0, 8'($urandom_range(0, 255)),
                              15'($urandom_range(0, 32767)), rand_stamp()));
      end
    end
  endtask

  task automatic write_register(input logic [pkr_pkg::CFG_INDEX_W-1:0] index,
                                input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_value <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(index, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] rec, input logic [15:0] batch, input int count,
                           input bit calm);
    write_register(pkr_pkg::CFG_RECORD_BYTES, rec);
    write_register(pkr_pkg::CFG_RECORDS_IN_BATCH, batch);
    steady     = calm;
    items_sent = 0;
    while (items_sent < count) random_packet(12);
    settle();
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_byte(out_data);
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    sb         = new();
    steady     = 1'b0;
    items_sent = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_value  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed requests at reset settings
    send_request(make_req(1'b0, 8'hFF, 15'h7FFF, '1));
    send_request(make_req(1'b1, 8'h00, 15'd0, 64'd0));
    send_request(make_req(1'b1, 8'hFF, 15'd1, '1));
    send_request(make_req(1'b1, 8'h5A, 15'd3, 64'h0123_4567_89AB_CDEF));
    send_request(make_req(1'b0, 8'h00, 15'd0, 64'd0));
    send_request(make_req(1'b0, 8'hFF, 15'h7FFF, '1));
    send_request(make_req(1'b0, 8'hA5, 15'd0, 64'd0));
    send_packet(32767, 3);
    send_packet(MAX_PACKET_BYTES, 2);
    send_packet(MAX_PACKET_BYTES + 1, 1);
    send_packet(5, 5);
    settle();

    // small records from the second record on
    write_register(pkr_pkg::CFG_RECORD_BYTES, 16'd16);
    while (sb.records_closed == 0) random_packet(1);
    settle();

    run_phase(16'd16, 16'hFFFF, 15, 1'b0);
    run_phase(16'd23, 16'd3, 15, 1'b1);
    write_register(CFG_SPARE_INDEX, 16'($urandom_range(0, 65535)));
    run_phase(16'd0, 16'd0, 10, 1'b0);
    run_phase(16'd17, 16'd4, 15, 1'b0);
    run_phase(16'd60, 16'd2, 12, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 8, 1'b0);

    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
